[rtl/cps_pkg.sv]
// shared types and constants for the critical path scheduler
// no dependencies
`default_nettype none
package cps_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;

  localparam int NODE_W  = $clog2(MAX_NODES);        // node index
  localparam int NCNT_W  = $clog2(MAX_NODES) + 1;    // node count
  localparam int EADDR_W = $clog2(MAX_EDGES);        // edge store address
  localparam int ECNT_W  = $clog2(MAX_EDGES) + 1;    // edge count
  localparam int DEG_W   = $clog2(MAX_EDGES) + 1;
  localparam int TIME_W  = 32;
  localparam int EDGE_W  = 2 * NODE_W + TIME_W;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);

  localparam logic [NCNT_W-1:0] NODE_LIMIT = NCNT_W'(MAX_NODES);
  localparam logic [ECNT_W-1:0] EDGE_LIMIT = ECNT_W'(MAX_EDGES);
  localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = NCNT_W'(1024);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CALC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] KIND_LENGTH = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              needs_out;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [TIME_W-1:0] duration;
  } cps_item_t;

  typedef struct packed {
    logic      valid;
    cps_item_t item;
  } cps_req_t;

endpackage
`default_nettype wire

[rtl/cps_front.sv]
// front end: takes requests, tags the ones that return a result, queues them
// depends on cps_pkg
`default_nettype none
module cps_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_cmd,
  input  wire logic [cps_pkg::NODE_W-1:0] in_from_node,
  input  wire logic [cps_pkg::NODE_W-1:0] in_to_node,
  input  wire logic [cps_pkg::TIME_W-1:0] in_duration,
  input  wire logic                     hold,
  output cps_pkg::cps_req_t             req,
  input  wire logic                     pop
);

  cps_pkg::cps_item_t           fq_mem [cps_pkg::FQ_DEPTH];
  logic [cps_pkg::FQ_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cps_pkg::FQ_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cps_pkg::FQ_AW:0]      cnt_r, cnt_nxt;
  cps_pkg::cps_item_t           item_in;
  logic                         push;
  logic                         do_pop;

  always_comb begin
    item_in.cmd       = in_cmd;
    item_in.needs_out = (in_cmd == cps_pkg::CMD_CALC) || (in_cmd == cps_pkg::CMD_READ);
    item_in.from_node = in_from_node;
    item_in.to_node   = in_to_node;
    item_in.duration  = in_duration;
  end

  assign in_ready  = (cnt_r != (cps_pkg::FQ_AW+1)'(cps_pkg::FQ_DEPTH)) && !hold;
  assign push      = in_valid && in_ready;
  assign req.valid = (cnt_r != '0);
  assign req.item  = fq_mem[rd_ptr_r];
  assign do_pop    = pop && req.valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq_mem[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/cps_back.sv]
// back end: edge store, node tables and the sequencer for both passes
// depends on cps_pkg
`default_nettype none
module cps_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [cps_pkg::NCNT_W-1:0]  node_count,
  input  cps_pkg::cps_req_t                req,
  output logic                             pop,
  output logic                             booting,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_result_kind,
  output logic [cps_pkg::TIME_W-1:0]       out_early_value,
  output logic [cps_pkg::TIME_W-1:0]       out_late_value,
  output logic                             out_edges_dropped
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_CLR      = 18'h00002,
    S_RD_E     = 18'h00004,
    S_RD_T     = 18'h00008,
    S_DEG_RD   = 18'h00010,
    S_DEG_NODE = 18'h00020,
    S_DEG_WR   = 18'h00040,
    S_SEED_RD  = 18'h00080,
    S_SEED_CHK = 18'h00100,
    S_POP      = 18'h00200,
    S_POPV     = 18'h00400,
    S_POPT     = 18'h00800,
    S_SCAN_RD  = 18'h01000,
    S_SCAN_CHK = 18'h02000,
    S_SCAN_UPD = 18'h04000,
    S_LEN_RD   = 18'h08000,
    S_LEN_CHK  = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  localparam int NW = cps_pkg::NODE_W;
  localparam int TW = cps_pkg::TIME_W;

  // memories
  logic [cps_pkg::EDGE_W-1:0] edge_mem  [cps_pkg::MAX_EDGES];
  logic [cps_pkg::DEG_W-1:0]  indeg_mem [cps_pkg::MAX_NODES];
  logic [cps_pkg::DEG_W-1:0]  outdeg_mem[cps_pkg::MAX_NODES];
  logic [TW-1:0]              early_mem [cps_pkg::MAX_NODES];
  logic [TW-1:0]              late_mem  [cps_pkg::MAX_NODES];
  logic [NW-1:0]              queue_mem [cps_pkg::MAX_NODES];

  logic                        edge_we, edge_re;
  logic [cps_pkg::EADDR_W-1:0] edge_waddr, edge_raddr;
  logic [cps_pkg::EDGE_W-1:0]  edge_wdata, edge_rd_r;
  logic                        in_we, in_re, out_we, out_re;
  logic [NW-1:0]               in_waddr, in_raddr, out_waddr, out_raddr;
  logic [cps_pkg::DEG_W-1:0]   in_wdata, out_wdata, in_rd_r, out_rd_r;
  logic                        ea_we, ea_re, la_we, la_re;
  logic [NW-1:0]               ea_waddr, ea_raddr, la_waddr, la_raddr;
  logic [TW-1:0]               ea_wdata, la_wdata, ea_rd_r, la_rd_r;
  logic                        q_we, q_re;
  logic [NW-1:0]               q_waddr, q_raddr, q_wdata, q_rd_r;

  state_t                      state_r, state_nxt;
  logic [cps_pkg::NCNT_W-1:0]  i_r, i_nxt, i_inc;
  logic [cps_pkg::ECNT_W-1:0]  k_r, k_nxt, k_inc;
  logic [cps_pkg::NCNT_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0]               v_r, v_nxt, t_r, t_nxt;
  logic [TW-1:0]               vt_r, vt_nxt, total_r, total_nxt;
  logic                        fwd_r, fwd_nxt, calc_r, calc_nxt, boot_r, boot_nxt;
  logic [cps_pkg::ECNT_W-1:0]  ecnt_r, ecnt_nxt, rp_r, rp_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        ov_r, ov_nxt;
  logic [1:0]                  okind_r, okind_nxt;
  logic [TW-1:0]               oearly_r, oearly_nxt, olate_r, olate_nxt;
  logic                        odrop_r, odrop_nxt;

  logic [cps_pkg::NCNT_W-1:0]  n_eff, n_len;
  logic [NW-1:0]               e_from, e_to;
  logic [TW-1:0]               e_dur;
  logic [cps_pkg::DEG_W-1:0]   deg_sel;
  logic [TW-1:0]               time_sel, cand;
  logic                        match;
  logic [NW-1:0]               t_sel;

  assign e_from   = edge_rd_r[cps_pkg::EDGE_W-1 -: NW];
  assign e_to     = edge_rd_r[TW +: NW];
  assign e_dur    = edge_rd_r[TW-1:0];
  assign n_eff    = (node_count > cps_pkg::NODE_LIMIT) ? cps_pkg::NODE_LIMIT : node_count;
  assign n_len    = (n_eff == '0) ? cps_pkg::NCNT_W'(1) : n_eff;
  assign i_inc    = i_r + 1'b1;
  assign k_inc    = k_r + 1'b1;
  assign deg_sel  = fwd_r ? in_rd_r : out_rd_r;
  assign time_sel = fwd_r ? ea_rd_r : la_rd_r;
  assign match    = fwd_r ? (e_from == v_r) : (e_to == v_r);
  assign t_sel    = fwd_r ? e_to : e_from;
  assign cand     = fwd_r ? (vt_r + e_dur) : (vt_r - e_dur);

  assign booting           = boot_r;
  assign out_valid         = ov_r;
  assign out_result_kind   = okind_r;
  assign out_early_value   = oearly_r;
  assign out_late_value    = olate_r;
  assign out_edges_dropped = odrop_r;

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    v_nxt      = v_r;
    t_nxt      = t_r;
    vt_nxt     = vt_r;
    total_nxt  = total_r;
    fwd_nxt    = fwd_r;
    calc_nxt   = calc_r;
    boot_nxt   = boot_r;
    ecnt_nxt   = ecnt_r;
    rp_nxt     = rp_r;
    ovf_nxt    = ovf_r;
    ov_nxt     = ov_r && !out_ready;
    okind_nxt  = okind_r;
    oearly_nxt = oearly_r;
    olate_nxt  = olate_r;
    odrop_nxt  = odrop_r;
    pop        = 1'b0;

    edge_we = 1'b0; edge_re = 1'b0;
    edge_waddr = ecnt_r[cps_pkg::EADDR_W-1:0];
    edge_raddr = k_r[cps_pkg::EADDR_W-1:0];
    edge_wdata = {req.item.from_node, req.item.to_node, req.item.duration};
    in_we = 1'b0; in_re = 1'b0; out_we = 1'b0; out_re = 1'b0;
    in_waddr = i_r[NW-1:0]; out_waddr = i_r[NW-1:0];
    in_raddr = i_r[NW-1:0]; out_raddr = i_r[NW-1:0];
    in_wdata = '0; out_wdata = '0;
    ea_we = 1'b0; ea_re = 1'b0; la_we = 1'b0; la_re = 1'b0;
    ea_waddr = i_r[NW-1:0]; la_waddr = i_r[NW-1:0];
    ea_raddr = i_r[NW-1:0]; la_raddr = i_r[NW-1:0];
    ea_wdata = '0; la_wdata = '1;
    q_we = 1'b0; q_re = 1'b0;
    q_waddr = tail_r[NW-1:0]; q_raddr = head_r[NW-1:0]; q_wdata = i_r[NW-1:0];

    case (state_r)
      S_IDLE: begin
        if (req.valid && (!req.item.needs_out || !ov_r)) begin
          pop = 1'b1;
          case (req.item.cmd)
            cps_pkg::CMD_ADD: begin
              if (ecnt_r < cps_pkg::EDGE_LIMIT) begin
                edge_we  = 1'b1;
                ecnt_nxt = ecnt_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            cps_pkg::CMD_CLEAR: begin
              ecnt_nxt  = '0;
              rp_nxt    = '0;
              total_nxt = '0;
              ovf_nxt   = 1'b0;
              i_nxt     = '0;
              calc_nxt  = 1'b0;
              state_nxt = S_CLR;
            end
            cps_pkg::CMD_CALC: begin
              i_nxt     = '0;
              calc_nxt  = 1'b1;
              fwd_nxt   = 1'b1;
              state_nxt = S_CLR;
            end
            cps_pkg::CMD_READ: begin
              if (rp_r < ecnt_r) begin
                edge_re    = 1'b1;
                edge_raddr = rp_r[cps_pkg::EADDR_W-1:0];
                state_nxt  = S_RD_E;
              end else begin
                ov_nxt     = 1'b1;
                okind_nxt  = cps_pkg::KIND_END;
                oearly_nxt = '0;
                olate_nxt  = '0;
                odrop_nxt  = ovf_r;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_E: begin
        ea_re = 1'b1; ea_raddr = e_from;
        la_re = 1'b1; la_raddr = e_to;
        state_nxt = S_RD_T;
      end
      S_RD_T: begin
        ov_nxt     = 1'b1;
        okind_nxt  = cps_pkg::KIND_EDGE;
        oearly_nxt = ea_rd_r;
        olate_nxt  = la_rd_r - e_dur;
        odrop_nxt  = ovf_r;
        rp_nxt     = rp_r + 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLR: begin
        // one node a cycle: degrees and earliest to zero, latest to all ones
        in_we = 1'b1; out_we = 1'b1; ea_we = 1'b1; la_we = 1'b1;
        i_nxt = i_inc;
        if (i_inc == cps_pkg::NODE_LIMIT) begin
          boot_nxt = 1'b0;
          k_nxt    = '0;
          i_nxt    = '0;
          head_nxt = '0;
          tail_nxt = '0;
          if (!calc_r) begin
            state_nxt = S_IDLE;
          end else if (ecnt_r != '0) begin
            state_nxt = S_DEG_RD;
          end else if (n_eff == '0) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_SEED_RD;
          end
        end
      end
      S_DEG_RD: begin
        edge_re   = 1'b1;
        state_nxt = S_DEG_NODE;
      end
      S_DEG_NODE: begin
        in_re = 1'b1; in_raddr = e_to;
        out_re = 1'b1; out_raddr = e_from;
        state_nxt = S_DEG_WR;
      end
      S_DEG_WR: begin
        in_we = 1'b1; in_waddr = e_to; in_wdata = in_rd_r + 1'b1;
        out_we = 1'b1; out_waddr = e_from; out_wdata = out_rd_r + 1'b1;
        k_nxt = k_inc;
        if (k_inc == ecnt_r) begin
          state_nxt = (n_eff == '0) ? S_POP : S_SEED_RD;
        end else begin
          state_nxt = S_DEG_RD;
        end
      end
      S_SEED_RD: begin
        in_re = 1'b1; out_re = 1'b1;
        state_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        if (deg_sel == '0 && tail_r < cps_pkg::NODE_LIMIT) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
          // sinks start at the project length
          if (!fwd_r) begin
            la_we    = 1'b1;
            la_wdata = total_r;
          end
        end
        i_nxt     = i_inc;
        state_nxt = (i_inc == n_eff) ? S_POP : S_SEED_RD;
      end
      S_POP: begin
        if (head_r < tail_r) begin
          q_re      = 1'b1;
          head_nxt  = head_r + 1'b1;
          state_nxt = S_POPV;
        end else if (fwd_r) begin
          i_nxt     = '0;
          state_nxt = S_LEN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POPV: begin
        v_nxt = q_rd_r;
        ea_re = 1'b1; ea_raddr = q_rd_r;
        la_re = 1'b1; la_raddr = q_rd_r;
        state_nxt = S_POPT;
      end
      S_POPT: begin
        vt_nxt    = time_sel;
        k_nxt     = '0;
        state_nxt = (ecnt_r == '0) ? S_POP : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        edge_re   = 1'b1;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (match) begin
          t_nxt = t_sel;
          in_re = 1'b1; in_raddr = t_sel;
          out_re = 1'b1; out_raddr = t_sel;
          ea_re = 1'b1; ea_raddr = t_sel;
          la_re = 1'b1; la_raddr = t_sel;
          state_nxt = S_SCAN_UPD;
        end else begin
          k_nxt     = k_inc;
          state_nxt = (k_inc == ecnt_r) ? S_POP : S_SCAN_RD;
        end
      end
      S_SCAN_UPD: begin
        if (deg_sel != '0) begin
          in_waddr = t_r; out_waddr = t_r;
          in_wdata = deg_sel - 1'b1; out_wdata = deg_sel - 1'b1;
          in_we  = fwd_r;
          out_we = !fwd_r;
          if (deg_sel == cps_pkg::DEG_W'(1) && tail_r < cps_pkg::NODE_LIMIT) begin
            q_we     = 1'b1;
            q_wdata  = t_r;
            tail_nxt = tail_r + 1'b1;
          end
        end
        if (fwd_r ? (cand > time_sel) : (cand < time_sel)) begin
          ea_waddr = t_r; la_waddr = t_r;
          ea_wdata = cand; la_wdata = cand;
          ea_we = fwd_r;
          la_we = !fwd_r;
          // self loop: the popped node's own time moves
          if (t_r == v_r) begin
            vt_nxt = cand;
          end
        end
        k_nxt     = k_inc;
        state_nxt = (k_inc == ecnt_r) ? S_POP : S_SCAN_RD;
      end
      S_LEN_RD: begin
        ea_re     = 1'b1;
        state_nxt = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        if (i_r == '0 || ea_rd_r > total_r) begin
          total_nxt = ea_rd_r;
        end
        i_nxt = i_inc;
        if (i_inc == n_len) begin
          fwd_nxt   = 1'b0;
          i_nxt     = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = (n_eff == '0) ? S_POP : S_SEED_RD;
        end else begin
          state_nxt = S_LEN_RD;
        end
      end
      S_DONE: begin
        rp_nxt     = '0;
        ov_nxt     = 1'b1;
        okind_nxt  = cps_pkg::KIND_LENGTH;
        oearly_nxt = total_r;
        olate_nxt  = '0;
        odrop_nxt  = ovf_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    if (edge_re) edge_rd_r <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_we) indeg_mem[in_waddr] <= in_wdata;
    if (in_re) in_rd_r <= indeg_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) outdeg_mem[out_waddr] <= out_wdata;
    if (out_re) out_rd_r <= outdeg_mem[out_raddr];
  end

  always_ff @(posedge clk) begin
    if (ea_we) early_mem[ea_waddr] <= ea_wdata;
    if (ea_re) ea_rd_r <= early_mem[ea_raddr];
  end

  always_ff @(posedge clk) begin
    if (la_we) late_mem[la_waddr] <= la_wdata;
    if (la_re) la_rd_r <= late_mem[la_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd_r <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r     <= '0;
      calc_r  <= 1'b0;
      boot_r  <= 1'b1;
      fwd_r   <= 1'b1;
      ecnt_r  <= '0;
      rp_r    <= '0;
      ovf_r   <= 1'b0;
      total_r <= '0;
      ov_r    <= 1'b0;
      k_r     <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      calc_r  <= calc_nxt;
      boot_r  <= boot_nxt;
      fwd_r   <= fwd_nxt;
      ecnt_r  <= ecnt_nxt;
      rp_r    <= rp_nxt;
      ovf_r   <= ovf_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      k_r     <= k_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    t_r      <= t_nxt;
    vt_r     <= vt_nxt;
    okind_r  <= okind_nxt;
    oearly_r <= oearly_nxt;
    olate_r  <= olate_nxt;
    odrop_r  <= odrop_nxt;
  end

endmodule
`default_nettype wire

[rtl/critical_path_schedule.sv]
// top level of the critical path scheduler: front queue, back sequencer,
// node_count register; depends on cps_pkg, cps_front, cps_back
//
//   port group | dir | handshake          | carries
//   in_*       | in  | in_valid/in_ready  | cmd, from_node, to_node, duration
//   out_*      | out | out_valid/out_ready| result_kind, early/late value, dropped
//   cfg_*      | in  | cfg_valid/cfg_ready| node_count
//
// add edge writes the edge store; read reads it, then the node tables
// clear then resets the node tables, one node a cycle
// compute: table clearing, then degree counting over the edges, then per pass
//   a seed scan over the nodes and, per popped node, a scan of every edge with
//   an update per match; between the passes a node scan for the project length
// after reset a clearing pass runs and in_ready stays low through it
// a 4-deep request queue sits between the front and the sequencer; the result
//   register lets the sequencer run adds and clears while a result waits
`default_nettype none
module critical_path_schedule (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [cps_pkg::NODE_W-1:0]  in_from_node,
  input  wire logic [cps_pkg::NODE_W-1:0]  in_to_node,
  input  wire logic [cps_pkg::TIME_W-1:0]  in_duration,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_result_kind,
  output logic [cps_pkg::TIME_W-1:0]       out_early_value,
  output logic [cps_pkg::TIME_W-1:0]       out_late_value,
  output logic                             out_edges_dropped,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [cps_pkg::NCNT_W-1:0]  cfg_node_count
);

  cps_pkg::cps_req_t           req;
  logic                        pop;
  logic                        booting;
  logic [cps_pkg::NCNT_W-1:0]  node_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= cps_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid) begin
      node_count_r <= cfg_node_count;
    end
  end

  cps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_from_node (in_from_node),
    .in_to_node   (in_to_node),
    .in_duration  (in_duration),
    .hold         (booting),
    .req          (req),
    .pop          (pop)
  );

  cps_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .node_count        (node_count_r),
    .req               (req),
    .pop               (pop),
    .booting           (booting),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_early_value   (out_early_value),
    .out_late_value    (out_late_value),
    .out_edges_dropped (out_edges_dropped)
  );

endmodule
`default_nettype wire

[rtl/cps_checker.sv]
// port-level checks for critical_path_schedule, attached by bind
// depends on cps_pkg
`default_nettype none
module cps_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  out_result_kind,
  input wire logic [cps_pkg::TIME_W-1:0]  out_early_value,
  input wire logic [cps_pkg::TIME_W-1:0]  out_late_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_early_value) && $stable(out_late_value))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_kind != 2'd3)
    else $error("bad result kind");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == cps_pkg::KIND_END) |->
      out_early_value == '0 && out_late_value == '0)
    else $error("end result carries data");

endmodule

bind critical_path_schedule cps_checker u_cps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_early_value (out_early_value),
  .out_late_value  (out_late_value)
);
`default_nettype wire
